// File: rtl/tcp_option_parser_core_defines.svh
// Assertion macros shared by the TCP option parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TCP_OPTION_PARSER_CORE_DEFINES_SVH
`define TCP_OPTION_PARSER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TCPOP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcpop check failed");

// antecedent implies consequent in the next cycle
`define TCPOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcpop check failed");

`endif

// File: rtl/tcpop_pkg.sv
// Package for the TCP option parser: option kinds, stop codes, parse state
// and result types. No dependencies.
package tcpop_pkg;

  localparam logic [7:0] KIND_END    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;
  localparam logic [7:0] KIND_TS     = 8'd8;

  localparam logic [7:0]  MIN_OPT_LEN = 8'd2;
  localparam logic [15:0] TS_RESERVE  = 16'd12;

  localparam int IN_W  = 40;
  localparam int RES_W = 110;
  localparam int OUT_W = 112;

  typedef enum logic [1:0] {
    STOP_EXHAUSTED = 2'd0,
    STOP_END       = 2'd1,
    STOP_BAD       = 2'd2
  } stop_t;

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  kind;
    logic [7:0]  left;
    logic [2:0]  idx;
    logic [31:0] shift;
    stop_t       stop;
    logic        mss_seen;
    logic [15:0] mss_value;
    logic        wscale_seen;
    logic [7:0]  wscale_value;
    logic        sack_ok;
    logic        ts_seen;
    logic [31:0] ts_val;
    logic [31:0] ts_time;
  } parse_st_t;

  localparam parse_st_t PARSE_RST = '{
    phase: PH_KIND, kind: '0, left: '0, idx: '0, shift: '0, stop: STOP_EXHAUSTED,
    mss_seen: 1'b0, mss_value: '0, wscale_seen: 1'b0, wscale_value: '0,
    sack_ok: 1'b0, ts_seen: 1'b0, ts_val: '0, ts_time: '0
  };

  // lowest field last
  typedef struct packed {
    stop_t       stop_status;
    logic [31:0] ts_update_time;
    logic [31:0] ts_recent_value;
    logic        ts_seen;
    logic        sack_ok;
    logic [7:0]  wscale_value;
    logic        wscale_seen;
    logic [15:0] eff_mss_value;
    logic [15:0] mss_value;
    logic        mss_seen;
  } result_t;

endpackage

// File: rtl/tcpop_step.sv
// One byte step of the option parser: next parse state and the result view.
// Depends on tcpop_pkg.
module tcpop_step (
  input  tcpop_pkg::parse_st_t st,
  input  logic [7:0]           opt_byte,
  input  logic [31:0]          now_ts,
  input  logic                 ts_enabled,
  output tcpop_pkg::parse_st_t st_nxt,
  output tcpop_pkg::result_t   res
);

  logic commit;

  always_comb begin
    st_nxt = st;
    commit = 1'b0;
    unique case (st.phase)
      tcpop_pkg::PH_KIND: begin
        if (opt_byte == tcpop_pkg::KIND_END) begin
          st_nxt.stop  = tcpop_pkg::STOP_END;
          st_nxt.phase = tcpop_pkg::PH_STOP;
        end else if (opt_byte != tcpop_pkg::KIND_NOP) begin
          st_nxt.kind  = opt_byte;
          st_nxt.phase = tcpop_pkg::PH_LEN;
        end
      end
      tcpop_pkg::PH_LEN: begin
        if (opt_byte < tcpop_pkg::MIN_OPT_LEN) begin
          st_nxt.stop  = tcpop_pkg::STOP_BAD;
          st_nxt.phase = tcpop_pkg::PH_STOP;
        end else begin
          st_nxt.left  = opt_byte - tcpop_pkg::MIN_OPT_LEN;
          st_nxt.idx   = '0;
          st_nxt.shift = '0;
          if (opt_byte == tcpop_pkg::MIN_OPT_LEN) begin
            commit = 1'b1;
          end else begin
            st_nxt.phase = tcpop_pkg::PH_DATA;
          end
        end
      end
      tcpop_pkg::PH_DATA: begin
        if (st.idx < 3'd4) begin
          st_nxt.shift = {st.shift[23:0], opt_byte};
          st_nxt.idx   = st.idx + 3'd1;
        end
        st_nxt.left = st.left - 8'd1;
        if (st.left == 8'd1) begin
          commit = 1'b1;
        end
      end
      default: ;
    endcase

    if (commit) begin
      st_nxt.phase = tcpop_pkg::PH_KIND;
      case (st_nxt.kind)
        tcpop_pkg::KIND_MSS: begin
          if (st_nxt.idx >= 3'd2) begin
            st_nxt.mss_seen = 1'b1;
            case (st_nxt.idx)
              3'd2:    st_nxt.mss_value = st_nxt.shift[15:0];
              3'd3:    st_nxt.mss_value = st_nxt.shift[23:8];
              default: st_nxt.mss_value = st_nxt.shift[31:16];
            endcase
          end
        end
        tcpop_pkg::KIND_WSCALE: begin
          if (st_nxt.idx >= 3'd1) begin
            st_nxt.wscale_seen = 1'b1;
            case (st_nxt.idx)
              3'd1:    st_nxt.wscale_value = st_nxt.shift[7:0];
              3'd2:    st_nxt.wscale_value = st_nxt.shift[15:8];
              3'd3:    st_nxt.wscale_value = st_nxt.shift[23:16];
              default: st_nxt.wscale_value = st_nxt.shift[31:24];
            endcase
          end
        end
        tcpop_pkg::KIND_SACKOK: st_nxt.sack_ok = 1'b1;
        tcpop_pkg::KIND_TS: begin
          if (st_nxt.idx >= 3'd4) begin
            st_nxt.ts_seen = 1'b1;
            st_nxt.ts_val  = st_nxt.shift;
            st_nxt.ts_time = now_ts;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.mss_seen        = st_nxt.mss_seen;
    res.mss_value       = st_nxt.mss_value;
    if (!ts_enabled) begin
      res.eff_mss_value = st_nxt.mss_value;
    end else if (st_nxt.mss_value >= tcpop_pkg::TS_RESERVE) begin
      res.eff_mss_value = st_nxt.mss_value - tcpop_pkg::TS_RESERVE;
    end else begin
      res.eff_mss_value = '0;
    end
    res.wscale_seen     = st_nxt.wscale_seen;
    res.wscale_value    = st_nxt.wscale_value;
    res.sack_ok         = st_nxt.sack_ok;
    res.ts_seen         = st_nxt.ts_seen;
    res.ts_recent_value = st_nxt.ts_val;
    res.ts_update_time  = st_nxt.ts_time;
    unique case (st_nxt.phase)
      tcpop_pkg::PH_KIND: res.stop_status = tcpop_pkg::STOP_EXHAUSTED;
      tcpop_pkg::PH_STOP: res.stop_status = st_nxt.stop;
      default:            res.stop_status = tcpop_pkg::STOP_BAD;
    endcase
  end

endmodule

// File: rtl/tcpop_obuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on tcpop_pkg.
module tcpop_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcpop_pkg::result_t  push_data,
  output logic                full,
  output logic                out_vld,
  output tcpop_pkg::result_t  out_data,
  input  logic                out_rdy
);

  logic               out_vld_r, skid_vld_r;
  tcpop_pkg::result_t out_r, skid_r;
  logic               pop;

  assign pop      = out_vld_r && out_rdy;
  assign full     = skid_vld_r;
  assign out_vld  = out_vld_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || pop) begin
      if (skid_vld_r) begin
        out_r      <= skid_r;
        out_vld_r  <= 1'b1;
        skid_vld_r <= push;
        skid_r     <= push_data;
      end else begin
        out_vld_r  <= push;
        out_r      <= push_data;
      end
    end else if (push) begin
      skid_r     <= push_data;
      skid_vld_r <= 1'b1;
    end
  end

endmodule

// File: rtl/tcp_option_parser_core.sv
// TCP option area parser, one option byte per request, one summary request
// per segment on the byte marked tlast. Takes a byte every clock cycle while
// in_tready is high; the parse state register is updated by a single short
// step, and the summary for a segment enters the output buffer when its last
// byte is accepted. A two-entry output buffer lets bytes keep flowing while a
// summary waits; in_tready only drops when both entries hold summaries.
// Depends on tcpop_pkg, tcpop_step, tcpop_obuf and the defines header.
`include "tcp_option_parser_core_defines.svh"

module tcp_option_parser_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,  // ts_enabled
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tcpop_pkg::IN_W-1:0]  in_tdata,     // opt_byte, now_ts
  input  logic                        in_tlast,     // last_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // mss_seen, mss_value, eff_mss_value, wscale_seen, wscale_value, sack_ok,
  // ts_seen, ts_recent_value, ts_update_time, stop_status, 2 zero bits
  output logic [tcpop_pkg::OUT_W-1:0] out_tdata
);

  logic                 ts_enabled_r;
  tcpop_pkg::parse_st_t st_r, st_nxt;
  tcpop_pkg::result_t   res, out_res;
  logic                 in_acc, buf_full;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !buf_full;

  tcpop_step u_step (
    .st         (st_r),
    .opt_byte   (in_tdata[7:0]),
    .now_ts     (in_tdata[39:8]),
    .ts_enabled (ts_enabled_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  tcpop_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && in_tlast),
    .push_data (res),
    .full      (buf_full),
    .out_vld   (out_tvalid),
    .out_data  (out_res),
    .out_rdy   (out_tready)
  );

  assign out_tdata = {{(tcpop_pkg::OUT_W - tcpop_pkg::RES_W){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_enabled_r <= 1'b1;
      st_r         <= tcpop_pkg::PARSE_RST;
    end else begin
      if (cfg_wr_en) begin
        ts_enabled_r <= cfg_wr_data;
      end
      if (in_acc) begin
        st_r <= in_tlast ? tcpop_pkg::PARSE_RST : st_nxt;
      end
    end
  end

  `TCPOP_ASSERT_NEXT(a_last_gives_out, clk, rst_n,
    in_acc && in_tlast && !out_tvalid, out_tvalid)
  `TCPOP_ASSERT_SAME(a_stop_legal, clk, rst_n, out_tvalid, out_tdata[109:108] != 2'd3)
  `TCPOP_ASSERT_SAME(a_mss_zero, clk, rst_n, out_tvalid && !out_tdata[0],
    out_tdata[32:1] == 32'd0)
  `TCPOP_ASSERT_SAME(a_full_has_out, clk, rst_n, !in_tready, out_tvalid)

endmodule

// File: test/tcp_option_parser_core_tb.sv
// Testbench for tcp_option_parser_core: streams directed and random TCP option
// areas byte by byte, predicts every segment summary in a scoreboard class and
// checks it field by field. Depends on tcpop_pkg and the parser RTL.
module tcp_option_parser_core_tb;
  import tcpop_pkg::*;

  localparam int unsigned CYCLE_LIMIT         = 300000;
  localparam int unsigned BYTES_PER_PHASE     = 170;
  localparam int unsigned BACKPRESSURE_CYCLES = 300;
  localparam int unsigned MAX_REPORTED        = 10;

  typedef enum int unsigned {NOW_RANDOM, NOW_ONES, NOW_ZERO} now_pattern_t;

  class opt_scoreboard;
    bit          ts_on;
    phase_t      ph;
    logic [7:0]  kind;
    logic [7:0]  left;
    logic [2:0]  idx;
    logic [31:0] shift;
    stop_t       stop;
    result_t     found;
    result_t     summary_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned stop_hits[3];

    function new();
      ts_on = 1'b1;
      mismatches = 0;
      checked = 0;
      stop_hits = '{0, 0, 0};
      clear_segment();
    endfunction

    function void clear_segment();
      ph = PH_KIND;
      kind = '0;
      left = '0;
      idx = '0;
      shift = '0;
      stop = STOP_EXHAUSTED;
      found = '0;
    endfunction

    function int pending();
      return summary_q.size();
    endfunction

    function void commit_option(logic [31:0] now);
      case (kind)
        KIND_MSS: if (idx >= 3'd2) begin
          found.mss_seen = 1'b1;
          found.mss_value = 16'(shift >> (8 * (idx - 3'd2)));
        end
        KIND_WSCALE: if (idx >= 3'd1) begin
          found.wscale_seen = 1'b1;
          found.wscale_value = 8'(shift >> (8 * (idx - 3'd1)));
        end
        KIND_SACKOK: found.sack_ok = 1'b1;
        KIND_TS: if (idx >= 3'd4) begin
          found.ts_seen = 1'b1;
          found.ts_recent_value = shift;
          found.ts_update_time = now;
        end
        default: ;
      endcase
      ph = PH_KIND;
    endfunction

    // one accepted option byte; a summary is due on the last byte
    function void note_byte(logic [7:0] b, bit last, logic [31:0] now);
      result_t sum;
      case (ph)
        PH_KIND: begin
          if (b == KIND_END) begin
            stop = STOP_END;
            ph = PH_STOP;
          end else if (b != KIND_NOP) begin
            kind = b;
            ph = PH_LEN;
          end
        end
        PH_LEN: begin
          if (b < MIN_OPT_LEN) begin
            stop = STOP_BAD;
            ph = PH_STOP;
          end else begin
            left = b - MIN_OPT_LEN;
            idx = '0;
            shift = '0;
            if (left == 8'd0) commit_option(now);
            else ph = PH_DATA;
          end
        end
        PH_DATA: begin
          if (idx < 3'd4) begin
            shift = {shift[23:0], b};
            idx = idx + 3'd1;
          end
          left = left - 8'd1;
          if (left == 8'd0) commit_option(now);
        end
        default: ;
      endcase
      if (!last) return;
      sum = found;
      case (ph)
        PH_KIND: sum.stop_status = STOP_EXHAUSTED;
        PH_STOP: sum.stop_status = stop;
        default: sum.stop_status = STOP_BAD;
      endcase
      sum.eff_mss_value = found.mss_value;
      if (ts_on)
        sum.eff_mss_value = (found.mss_value >= TS_RESERVE) ?
                            found.mss_value - TS_RESERVE : 16'd0;
      summary_q.push_back(sum);
      clear_segment();
    endfunction

    function void check_summary(result_t got);
      result_t want;
      if (summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected summary: got %p", got);
        return;
      end
      want = summary_q.pop_front();
      checked++;
      stop_hits[int'(want.stop_status)]++;
      if (got.mss_seen !== want.mss_seen || got.mss_value !== want.mss_value ||
          got.eff_mss_value !== want.eff_mss_value ||
          got.wscale_seen !== want.wscale_seen ||
          got.wscale_value !== want.wscale_value || got.sack_ok !== want.sack_ok ||
          got.ts_seen !== want.ts_seen || got.ts_recent_value !== want.ts_recent_value ||
          got.ts_update_time !== want.ts_update_time ||
          got.stop_status !== want.stop_status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("summary %0d mismatch:\n  expected %p\n  actual   %p", checked, want, got);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  opt_scoreboard sb;
  logic [7:0]    seg_bytes[$];
  bit            tx_burst = 1'b0;
  int unsigned   bytes_sent = 0;
  int unsigned   segments_sent = 0;
  int unsigned   noise_segments = 0;
  int unsigned   cycle_count = 0;

  tcp_option_parser_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d summaries outstanding", cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit last, input logic [31:0] now,
                           input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last, now);
    bytes_sent++;
  endtask

  task automatic send_segment(input now_pattern_t pattern);
    logic [31:0] now;
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
    foreach (seg_bytes[i]) begin
      case (pattern)
        NOW_ONES: now = '1;
        NOW_ZERO: now = '0;
        default:  now = $urandom;
      endcase
      gap = tx_burst ? 0 : $urandom_range(0, 8);
      push_byte(seg_bytes[i], i == seg_bytes.size() - 1, now, gap);
    end
    segments_sent++;
  endtask

  // mostly nominal lengths, some short, some long, rarely very long
  task automatic add_option(input logic [7:0] kind, input int unsigned nominal);
    int unsigned len;
    int unsigned roll;
    int unsigned pos;
    roll = $urandom_range(0, 99);
    if (roll < 70) len = nominal;
    else if (roll < 85) len = $urandom_range(2, nominal);
    else if (roll < 99) len = nominal + $urandom_range(1, 6);
    else len = $urandom_range(nominal, 255);
    seg_bytes.push_back(kind);
    seg_bytes.push_back(8'(len));
    pos = seg_bytes.size();
    for (int i = 2; i < len; i++) seg_bytes.push_back(8'($urandom));
    if (kind == KIND_MSS && len >= 4 && $urandom_range(0, 3) == 0) begin
      seg_bytes[pos] = 8'h00;
      seg_bytes[pos + 1] = 8'($urandom_range(0, 20));
    end
  endtask

  task automatic build_segment();
    int unsigned roll;
    int unsigned cut;
    logic [7:0]  k;
    seg_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) seg_bytes.push_back(8'($urandom));
      noise_segments++;
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) seg_bytes.push_back(KIND_NOP);
      else if (roll < 32) add_option(KIND_MSS, 4);
      else if (roll < 50) add_option(KIND_WSCALE, 3);
      else if (roll < 62) add_option(KIND_SACKOK, 2);
      else if (roll < 82) add_option(KIND_TS, 10);
      else begin
        k = 8'($urandom_range(5, 255));
        if (k == KIND_TS) k = KIND_TS + 8'd1;
        add_option(k, $urandom_range(2, 10));
      end
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      seg_bytes.push_back(KIND_END);
      repeat ($urandom_range(0, 4)) seg_bytes.push_back(8'($urandom));
    end else if (roll < 14) begin
      seg_bytes.push_back(8'($urandom_range(2, 255)));
      seg_bytes.push_back(8'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 4)) seg_bytes.push_back(8'($urandom));
    end else if (roll < 26 && seg_bytes.size() > 1) begin
      cut = $urandom_range(1, seg_bytes.size() - 1);
      while (seg_bytes.size() > cut) void'(seg_bytes.pop_back());
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ts(input bit value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.ts_on = value;
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int unsigned stall;
    bit          quiet;
    bit          held;
    result_t     got;
    out_tready = 1'b0;
    quiet = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= 12) begin
        held = 1'b1;
        stall = BACKPRESSURE_CYCLES;
      end else begin
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        stall = quiet ? 0 : $urandom_range(0, 8);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = result_t'(out_tdata[RES_W-1:0]);
      sb.check_summary(got);
    end
  end

  initial begin
    int unsigned phase_start;
    sb = new();
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed segments with ts_enabled at its reset value
    seg_bytes = '{KIND_TS, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    send_segment(NOW_ONES);
    seg_bytes = '{KIND_MSS, 8'd4, 8'h00, 8'h05, KIND_NOP, KIND_WSCALE, 8'd3, 8'hFF,
                  KIND_SACKOK, 8'd2};
    send_segment(NOW_ZERO);
    seg_bytes = '{KIND_MSS, 8'd4, 8'hFF, 8'hFF, KIND_END, 8'h55};
    send_segment(NOW_RANDOM);
    seg_bytes = '{8'd5, 8'd1, 8'h99};
    send_segment(NOW_RANDOM);
    seg_bytes = '{KIND_MSS};
    send_segment(NOW_RANDOM);
    seg_bytes = '{KIND_NOP};
    send_segment(NOW_RANDOM);

    for (int p = 0; p < 4; p++) begin
      drain_and_settle();
      write_ts(p % 2 != 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        build_segment();
        send_segment(NOW_RANDOM);
      end
    end
    drain_and_settle();

    $display("Run: %0d option bytes in %0d segments (%0d noise), ts_enabled both ways, %s",
             bytes_sent, segments_sent, noise_segments, "one long result-side hold-off.");
    $display("%0d summaries checked (exhausted %0d, end option %0d, truncated/bad %0d), %0d %s",
             sb.checked, sb.stop_hits[0], sb.stop_hits[1], sb.stop_hits[2], sb.mismatches,
             "mismatches.");
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
